@@ rtl/brrf_pkg.sv @@
// Shared constants for the bus receive ring buffer.
// No dependencies; every other file of the block imports this package.
package brrf_pkg;

	// Field widths of the request and response transfers.
	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;
	localparam int FILL_W = 4;

	// Default number of store entries; one entry always stays free.
	localparam int DEPTH_DEF = 16;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_PUSH      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP       = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SET_REPLY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BUS_READ  = 2'd3;

	// Reply register value after reset.
	localparam logic [BYTE_W-1:0] REPLY_RESET = 8'hff;

endpackage

@@ rtl/brrf_req_if.sv @@
// Request channel of the bus receive ring buffer: valid, ready and one request.
// Depends on brrf_pkg for the field widths.
interface brrf_req_if import brrf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] byte_in;

	modport source (output valid, kind, byte_in, input ready);
	modport sink   (input valid, kind, byte_in, output ready);
endinterface

@@ rtl/brrf_rsp_if.sv @@
// Response channel of the bus receive ring buffer: valid, ready and one result.
// Depends on brrf_pkg for the field widths.
interface brrf_rsp_if import brrf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] popped_byte;
	logic              popped_valid;
	logic [BYTE_W-1:0] head_byte;
	logic              head_valid;
	logic [FILL_W-1:0] fill_count;
	logic              dropped_oldest;
	logic [BYTE_W-1:0] reply_byte;

	modport source (output valid, popped_byte, popped_valid, head_byte, head_valid,
		fill_count, dropped_oldest, reply_byte, input ready);
	modport sink   (input valid, popped_byte, popped_valid, head_byte, head_valid,
		fill_count, dropped_oldest, reply_byte, output ready);
endinterface

@@ rtl/brrf_mem.sv @@
// Byte store of the ring buffer: one write port, one registered read port.
// Depends on brrf_pkg for the byte width.
module brrf_mem import brrf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [BYTE_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [BYTE_W-1:0]        rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];

	// Write port; entries have no reset and are only read after being written.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; old data on a same-address write.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/bus_receive_ring_fifo.sv @@
// Top level of the bus receive ring buffer: pointer control, reply register
// and response register around the byte store. Depends on brrf_pkg,
// brrf_req_if, brrf_rsp_if and brrf_mem.
//
//   channel  modport  payload
//   req      sink     kind, byte_in
//   rsp      source   popped_byte, popped_valid, head_byte, head_valid,
//                     fill_count, dropped_oldest, reply_byte
//
// Each request passes the sequencer states in order: the accept in the idle state
// updates the pointers and writes a pushed byte, the pop state takes the popped byte
// and the head state the new head byte through the single read port of the store.
// A new request is taken as soon as the previous result sits in the response
// register, even while that result waits for rsp.ready.
// Reset clears both pointers and loads 0xff into the reply register; the store
// itself is not cleared.
module bus_receive_ring_fifo import brrf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	brrf_req_if.sink    req,
	brrf_rsp_if.source  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_HEAD = 2'd2;

	logic [1:0]        state_q;
	logic [AW-1:0]     rp_q;
	logic [AW-1:0]     wp_q;
	logic [BYTE_W-1:0] reply_q;
	logic              pop_hit_q;
	logic              dropped_q;
	logic [BYTE_W-1:0] popped_q;

	logic              accept;
	logic              mem_we;
	logic [BYTE_W-1:0] mem_rdata;
	logic [AW-1:0]     wp_next;
	logic [AW:0]       fill;
	logic              nonempty;
	logic              out_load;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign mem_we    = accept && (req.kind == KIND_PUSH);
	assign wp_next   = ring_next(wp_q);

	// The read address is always the read pointer: the old one in the accept
	// cycle for a pop, the updated one afterwards for the head byte.
	brrf_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (req.byte_in),
		.raddr (rp_q),
		.rdata (mem_rdata)
	);

	// Occupancy from the pointers after the update.
	assign nonempty = (rp_q != wp_q);
	assign fill = (wp_q >= rp_q) ? ({1'b0, wp_q} - {1'b0, rp_q})
		: ((AW+1)'(DEPTH) + {1'b0, wp_q} - {1'b0, rp_q});

	assign out_load = (state_q == ST_HEAD) && (!rsp.valid || rsp.ready);

	// Pointer, reply register and sequencer update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rp_q      <= '0;
			wp_q      <= '0;
			reply_q   <= REPLY_RESET;
			pop_hit_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pop_hit_q <= 1'b0;
						dropped_q <= 1'b0;
						case (req.kind)
							KIND_PUSH: begin
								wp_q <= wp_next;
								if (wp_next == rp_q) begin
									rp_q      <= ring_next(rp_q);
									dropped_q <= 1'b1;
								end
							end
							KIND_POP: begin
								if (rp_q != wp_q) begin
									rp_q      <= ring_next(rp_q);
									pop_hit_q <= 1'b1;
								end
							end
							KIND_SET_REPLY: begin
								reply_q <= req.byte_in;
							end
							default: begin
							end
						endcase
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Popped byte, taken from the read port in the pop state.
	always_ff @(posedge clk) begin
		if (state_q == ST_POP) begin
			popped_q <= pop_hit_q ? mem_rdata : '0;
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (out_load) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	// Response payload; the read port keeps the head byte while the
	// response register is still occupied.
	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.popped_byte    <= popped_q;
			rsp.popped_valid   <= pop_hit_q;
			rsp.head_byte      <= nonempty ? mem_rdata : '0;
			rsp.head_valid     <= nonempty;
			rsp.fill_count     <= FILL_W'(fill);
			rsp.dropped_oldest <= dropped_q;
			rsp.reply_byte     <= reply_q;
		end
	end

	// Both pointers always address an existing entry.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rp_q <= LAST) && (wp_q <= LAST))
		else $error("ring pointer beyond last entry");

	// An accepted request always moves on to the pop read.
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_POP))
		else $error("sequencer did not advance after a transfer");

	// Dropping the oldest byte only happens with the buffer full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && dropped_q) |-> (fill == (AW+1)'(DEPTH - 1)))
		else $error("oldest byte dropped while buffer not full");

	// A successful pop never leaves the buffer full.
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && pop_hit_q) |-> (fill != (AW+1)'(DEPTH - 1)))
		else $error("buffer full right after a pop");

endmodule

@@ tb/tb_bus_receive_ring_fifo.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the bus receive ring buffer: random and directed requests
// against a cycle-free tracker of the pointers, the store and the reply register.
// Depends on brrf_pkg, brrf_req_if, brrf_rsp_if and bus_receive_ring_fifo.
module tb_bus_receive_ring_fifo;
	import brrf_pkg::*;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int STALL_LIMIT   = 5000;
	localparam int IDLE_PERCENT  = 32;
	localparam int CALM_FIRST    = 1500;
	localparam int CALM_LAST     = 3000;
	localparam int DRAIN_AT      = 1000;
	localparam int TAIL_CYCLES   = 20;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic              drain;
	} request_t;

	typedef struct packed {
		logic [BYTE_W-1:0] popped_byte;
		logic              popped_valid;
		logic [BYTE_W-1:0] head_byte;
		logic              head_valid;
		logic [FILL_W-1:0] fill_count;
		logic              dropped_oldest;
		logic [BYTE_W-1:0] reply_byte;
	} status_t;

	logic clk = 1'b0;
	logic arst_n;

	brrf_req_if req ();
	brrf_rsp_if rsp ();

	bus_receive_ring_fifo #(.DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #5 clk = ~clk;

	// Requests waiting to be driven and statuses waiting to be returned.
	request_t request_q[$];
	status_t  status_q[$];

	// Tracked copy of the ring buffer and the reply register.
	logic [BYTE_W-1:0] ring_copy [DEPTH];
	int                rd_idx;
	int                wr_idx;
	logic [BYTE_W-1:0] reply_copy;

	int errors      = 0;
	int cycle_n     = 0;
	int stall_n     = 0;
	int n_push      = 0;
	int n_drop      = 0;
	int n_pop_hit   = 0;
	int n_pop_empty = 0;
	int n_checked   = 0;

	// Quiet window in which neither side idles.
	wire calm = (cycle_n >= CALM_FIRST) && (cycle_n < CALM_LAST);

	// Apply one accepted request to the tracked state and queue the status it yields.
	task automatic track_request(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b);
		status_t s;
		s = '0;
		case (kind)
			KIND_PUSH: begin
				ring_copy[wr_idx] = b;
				wr_idx = (wr_idx + 1) % DEPTH;
				n_push++;
				if (wr_idx == rd_idx) begin
					// Full buffer: the oldest unread byte is lost.
					rd_idx = (rd_idx + 1) % DEPTH;
					s.dropped_oldest = 1'b1;
					n_drop++;
				end
			end
			KIND_POP: begin
				if (rd_idx != wr_idx) begin
					s.popped_byte  = ring_copy[rd_idx];
					s.popped_valid = 1'b1;
					rd_idx = (rd_idx + 1) % DEPTH;
					n_pop_hit++;
				end else begin
					n_pop_empty++;
				end
			end
			KIND_SET_REPLY: reply_copy = b;
			default: ;
		endcase
		s.head_valid = (rd_idx != wr_idx);
		s.head_byte  = s.head_valid ? ring_copy[rd_idx] : '0;
		s.fill_count = FILL_W'((wr_idx - rd_idx + DEPTH) % DEPTH);
		s.reply_byte = reply_copy;
		status_q.push_back(s);
	endtask

	task automatic add_request(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
			input logic drain = 1'b0);
		request_t r;
		r.kind  = kind;
		r.data  = b;
		r.drain = drain;
		request_q.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Request driver: a new transfer is offered only once the previous one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid   <= 1'b0;
			req.kind    <= KIND_PUSH;
			req.byte_in <= '0;
			rd_idx      = 0;
			wr_idx      = 0;
			reply_copy  = REPLY_RESET;
		end else begin
			if (req.valid && req.ready)
				track_request(req.kind, req.byte_in);
			if (!req.valid || req.ready) begin
				if (request_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)
						&& !(request_q[0].drain && status_q.size() != 0)) begin
					req.valid   <= 1'b1;
					req.kind    <= request_q[0].kind;
					req.byte_in <= request_q[0].data;
					void'(request_q.pop_front());
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: random back-pressure and field-by-field comparison.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					$error("response transfer with no status expected");
					errors++;
				end else begin
					status_t s;
					s = status_q.pop_front();
					check_field("popped_byte", s.popped_byte, rsp.popped_byte);
					check_field("popped_valid", BYTE_W'(s.popped_valid),
						BYTE_W'(rsp.popped_valid));
					check_field("head_byte", s.head_byte, rsp.head_byte);
					check_field("head_valid", BYTE_W'(s.head_valid), BYTE_W'(rsp.head_valid));
					check_field("fill_count", BYTE_W'(s.fill_count), BYTE_W'(rsp.fill_count));
					check_field("dropped_oldest", BYTE_W'(s.dropped_oldest),
						BYTE_W'(rsp.dropped_oldest));
					check_field("reply_byte", s.reply_byte, rsp.reply_byte);
					n_checked++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			stall_n <= 0;
		else
			stall_n <= stall_n + 1;
		if (stall_n >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int mode;
		int left;
		int pick;
		logic [KIND_W-1:0] k;

		arst_n      = 1'b0;

		// Directed part: empty pop, reply register, byte extremes, overflow past full.
		add_request(KIND_POP, 8'hff);
		add_request(KIND_BUS_READ, 8'h00);
		add_request(KIND_SET_REPLY, 8'h00);
		add_request(KIND_BUS_READ, 8'hff);
		add_request(KIND_PUSH, 8'h00);
		add_request(KIND_PUSH, 8'hff);
		add_request(KIND_PUSH, 8'h80);
		add_request(KIND_PUSH, 8'h7f);
		for (int i = 0; i < DEPTH - 3; i++)
			add_request(KIND_PUSH, (i % 2) ? 8'h55 : 8'haa);
		add_request(KIND_POP, 8'h00);
		add_request(KIND_SET_REPLY, 8'h80);
		add_request(KIND_BUS_READ, 8'h5a);

		// Random part: stretches that favor filling, draining or a balanced mix.
		mode = 0;
		left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (left == 0) begin
				mode = $urandom_range(2);
				left = $urandom_range(80, 30);
			end
			left--;
			pick = $urandom_range(99);
			case (mode)
				0:       k = (pick < 70) ? KIND_PUSH : (pick < 85) ? KIND_POP :
						(pick < 92) ? KIND_SET_REPLY : KIND_BUS_READ;
				1:       k = (pick < 20) ? KIND_PUSH : (pick < 85) ? KIND_POP :
						(pick < 92) ? KIND_SET_REPLY : KIND_BUS_READ;
				default: k = KIND_W'($urandom_range(3));
			endcase
			add_request(k, BYTE_W'($urandom), i == DRAIN_AT);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || req.valid)
			@(posedge clk);
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (status_q.size() != 0)
			$error("%0d statuses never returned", status_q.size());

		$display("Checked %0d responses: %0d pushes, %0d of them overwriting the oldest byte,",
			n_checked, n_push, n_drop);
		$display("%0d pops with data and %0d pops of an empty buffer.", n_pop_hit, n_pop_empty);
		if (errors == 0 && status_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/brrf_pkg.sv
rtl/brrf_req_if.sv
rtl/brrf_rsp_if.sv
rtl/brrf_mem.sv
rtl/bus_receive_ring_fifo.sv
tb/tb_bus_receive_ring_fifo.sv
